>>> hdl/rthc_pkg.sv
package rthc_pkg;

  // channel width of red, green, blue and brightness
  localparam int CHANNEL_BITS = 8;

  // Q0.16 hue and saturation
  localparam int FRAC_BITS = 16;

  // divisor width: 6*chroma needs three bits above a channel
  localparam int DIV_W = CHANNEL_BITS + 3;
  // hue numerator before wrap: range -chroma .. 5*chroma, one sign bit more
  localparam int NUM_W = DIV_W + 1;

  // quotient bits resolved per back-end stage
  localparam int BITS_PER_STAGE = 2;
  localparam int DIV_STAGES = FRAC_BITS / BITS_PER_STAGE;
  localparam int STAGE_W = $clog2(DIV_STAGES + 1);

  // decoupling queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

  // hue sector base is 0, 2 or 4 times chroma: shifts for the latter two
  localparam int SECTOR_GREEN_SHIFT = 1;
  localparam int SECTOR_BLUE_SHIFT = 2;

  // stream widths, rounded up to whole bytes
  localparam int S_DATA_W = ((3 * CHANNEL_BITS + 7) / 8) * 8;
  localparam int M_DATA_W = ((2 * FRAC_BITS + CHANNEL_BITS + 7) / 8) * 8;

  // one classified pixel, ready for division
  typedef struct packed {
    logic [DIV_W-1:0]        hue_num;    // wrapped numerator, below hue_den
    logic [DIV_W-1:0]        hue_den;    // 6 * chroma
    logic [CHANNEL_BITS-1:0] sat_num;    // chroma
    logic [CHANNEL_BITS-1:0] brightness; // max channel, also sat divisor
    logic                    hue_zero;   // grey pixel
    logic                    sat_zero;   // black pixel
    logic                    sat_max;    // min channel zero: quotient is one
  } rthc_item_t;

endpackage

>>> hdl/rthc_front.sv
module rthc_front
  import rthc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [CHANNEL_BITS-1:0] red,
  input  logic [CHANNEL_BITS-1:0] green,
  input  logic [CHANNEL_BITS-1:0] blue,
  output logic                    out_valid,
  input  logic                    out_ready,
  output rthc_item_t              out_item
);

  logic                    valid;
  rthc_item_t              item;
  rthc_item_t              item_next;

  logic [CHANNEL_BITS-1:0] hi;
  logic [CHANNEL_BITS-1:0] lo;
  logic [CHANNEL_BITS-1:0] chroma;
  logic [NUM_W-1:0]        base;
  logic [NUM_W-1:0]        plus;
  logic [NUM_W-1:0]        minus;
  logic [NUM_W-1:0]        num;
  logic [NUM_W-1:0]        num_wrap;
  logic [DIV_W-1:0]        den6;

  always_comb begin
    hi = red;
    if (green > hi) hi = green;
    if (blue > hi) hi = blue;
    lo = red;
    if (green < lo) lo = green;
    if (blue < lo) lo = blue;
    chroma = hi - lo;
    den6 = (DIV_W'(chroma) << SECTOR_BLUE_SHIFT) + (DIV_W'(chroma) << SECTOR_GREEN_SHIFT);

    // first channel equal to max wins, red then green then blue
    priority if (hi == red) begin
      base  = '0;
      plus  = NUM_W'(green);
      minus = NUM_W'(blue);
    end else if (hi == green) begin
      base  = NUM_W'(chroma) << SECTOR_GREEN_SHIFT;
      plus  = NUM_W'(blue);
      minus = NUM_W'(red);
    end else begin
      base  = NUM_W'(chroma) << SECTOR_BLUE_SHIFT;
      plus  = NUM_W'(red);
      minus = NUM_W'(green);
    end

    // modular arithmetic; a negative numerator gets one full turn added
    num = base + plus - minus;
    num_wrap = num[NUM_W-1] ? (num + NUM_W'(den6)) : num;

    item_next.hue_num    = num_wrap[DIV_W-1:0];
    item_next.hue_den    = den6;
    item_next.sat_num    = chroma;
    item_next.brightness = hi;
    item_next.hue_zero   = (chroma == '0);
    item_next.sat_zero   = (hi == '0);
    item_next.sat_max    = (lo == '0) && (hi != '0);
  end

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= item_next;
    end
  end

endmodule

>>> hdl/rthc_queue.sv
module rthc_queue
  import rthc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  rthc_item_t in_item,
  output logic       out_valid,
  input  logic       out_ready,
  output rthc_item_t out_item
);

  rthc_item_t          slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;
  logic                push;
  logic                pop;

  assign in_ready  = (count != (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QUEUE_AW'(1);
      if (pop) rd_ptr <= rd_ptr + QUEUE_AW'(1);
      unique case ({push, pop})
        2'b10:   count <= count + (QUEUE_AW+1)'(1);
        2'b01:   count <= count - (QUEUE_AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QUEUE_AW+1)'(QUEUE_DEPTH))
    else $error("queue fill count beyond depth");

  a_ptr_track: assert property (@(posedge clk) disable iff (rst)
    (rd_ptr + count[QUEUE_AW-1:0]) == wr_ptr)
    else $error("queue pointers disagree with fill count");

endmodule

>>> hdl/rthc_back.sv
module rthc_back
  import rthc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  rthc_item_t              in_item,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [FRAC_BITS-1:0]    hue,
  output logic [FRAC_BITS-1:0]    saturation,
  output logic [CHANNEL_BITS-1:0] brightness
);

  // per-stage divider state; index 0 is the entry stage, DIV_STAGES the output
  logic                    vld      [DIV_STAGES+1];
  logic [DIV_W-1:0]        hrem     [DIV_STAGES+1];
  logic [DIV_W-1:0]        hden     [DIV_STAGES+1];
  logic [FRAC_BITS-1:0]    hq       [DIV_STAGES+1];
  logic [CHANNEL_BITS-1:0] srem     [DIV_STAGES+1];
  logic [CHANNEL_BITS-1:0] sden     [DIV_STAGES+1];
  logic [FRAC_BITS-1:0]    sq       [DIV_STAGES+1];
  logic                    hzero    [DIV_STAGES+1];
  logic                    szero    [DIV_STAGES+1];
  logic                    smax     [DIV_STAGES+1];

  logic [DIV_W-1:0]        hrem_next [DIV_STAGES];
  logic [FRAC_BITS-1:0]    hq_next   [DIV_STAGES];
  logic [CHANNEL_BITS-1:0] srem_next [DIV_STAGES];
  logic [FRAC_BITS-1:0]    sq_next   [DIV_STAGES];

  logic advance;

  // whole pipeline moves unless the output register is held
  assign advance  = !vld[DIV_STAGES] || out_ready;
  assign in_ready = advance;

  // restoring division, BITS_PER_STAGE quotient bits per stage, both dividers
  always_comb begin
    logic [DIV_W:0]        ht;
    logic [DIV_W-1:0]      hr;
    logic [FRAC_BITS-1:0]  hqq;
    logic [CHANNEL_BITS:0] st;
    logic [CHANNEL_BITS-1:0] sr;
    logic [FRAC_BITS-1:0]  sqq;
    for (int s = 0; s < DIV_STAGES; s++) begin
      hr  = hrem[s];
      hqq = hq[s];
      sr  = srem[s];
      sqq = sq[s];
      for (int b = 0; b < BITS_PER_STAGE; b++) begin
        ht = {hr, 1'b0};
        if (ht >= {1'b0, hden[s]}) begin
          hr  = DIV_W'(ht - {1'b0, hden[s]});
          hqq = {hqq[FRAC_BITS-2:0], 1'b1};
        end else begin
          hr  = ht[DIV_W-1:0];
          hqq = {hqq[FRAC_BITS-2:0], 1'b0};
        end
        st = {sr, 1'b0};
        if (st >= {1'b0, sden[s]}) begin
          sr  = CHANNEL_BITS'(st - {1'b0, sden[s]});
          sqq = {sqq[FRAC_BITS-2:0], 1'b1};
        end else begin
          sr  = st[CHANNEL_BITS-1:0];
          sqq = {sqq[FRAC_BITS-2:0], 1'b0};
        end
      end
      hrem_next[s] = hr;
      hq_next[s]   = hqq;
      srem_next[s] = sr;
      sq_next[s]   = sqq;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= DIV_STAGES; s++) vld[s] <= 1'b0;
    end else if (advance) begin
      vld[0] <= in_valid;
      for (int s = 0; s < DIV_STAGES; s++) vld[s+1] <= vld[s];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      hrem[0]  <= in_item.hue_num;
      hden[0]  <= in_item.hue_den;
      hq[0]    <= '0;
      srem[0]  <= in_item.sat_num;
      sden[0]  <= in_item.brightness;
      sq[0]    <= '0;
      hzero[0] <= in_item.hue_zero;
      szero[0] <= in_item.sat_zero;
      smax[0]  <= in_item.sat_max;
      for (int s = 0; s < DIV_STAGES; s++) begin
        hrem[s+1]  <= hrem_next[s];
        hden[s+1]  <= hden[s];
        hq[s+1]    <= hq_next[s];
        srem[s+1]  <= srem_next[s];
        sden[s+1]  <= sden[s];
        sq[s+1]    <= sq_next[s];
        hzero[s+1] <= hzero[s];
        szero[s+1] <= szero[s];
        smax[s+1]  <= smax[s];
      end
    end
  end

  assign out_valid  = vld[DIV_STAGES];
  assign brightness = sden[DIV_STAGES];
  assign hue        = hzero[DIV_STAGES] ? '0 : hq[DIV_STAGES];
  always_comb begin
    priority if (szero[DIV_STAGES]) saturation = '0;
    else if (smax[DIV_STAGES])      saturation = '1;
    else                            saturation = sq[DIV_STAGES];
  end

  a_hue_entry: assert property (@(posedge clk) disable iff (rst)
    vld[0] && !hzero[0] |-> hrem[0] < hden[0])
    else $error("hue numerator not wrapped below divisor");

  a_hue_rem: assert property (@(posedge clk) disable iff (rst)
    vld[DIV_STAGES] && !hzero[DIV_STAGES] |-> hrem[DIV_STAGES] < hden[DIV_STAGES])
    else $error("hue remainder not below divisor");

  a_sat_rem: assert property (@(posedge clk) disable iff (rst)
    vld[DIV_STAGES] && !szero[DIV_STAGES] && !smax[DIV_STAGES]
      |-> srem[DIV_STAGES] < sden[DIV_STAGES])
    else $error("saturation remainder not below divisor");

endmodule

>>> hdl/rgb_to_hsv_converter_core.sv
// RGB to HSV converter, one pixel per item.
//
// Input stream s_*: one pixel per item, red, green and blue channels.
// Output stream m_*: one result per pixel, hue and saturation as unsigned
// Q0.16 fractions and brightness as the largest channel. Results leave in
// input order.
//
// Path from input acceptance to m_tvalid: front register, queue, then an
// eight-stage divider pipeline with two quotient bits resolved per stage.
// Throughput: one pixel per clock while the receiver does not stall; the divider pipeline is fully pipelined.
//
// Reset (rst, synchronous): flushes the front register, the queue and the
// divider valids; nothing held is delivered afterwards.
// Receiver stall: the divider pipeline freezes while m_tvalid is high and
// m_tready is low. The front keeps accepting into the four-entry queue until
// it fills, then s_tready drops.
module rgb_to_hsv_converter_core
  import rthc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,   // red, green, blue
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata    // hue, saturation, brightness
);

  rthc_item_t              front_item;
  rthc_item_t              queue_item;
  logic                    front_valid;
  logic                    front_ready;
  logic                    queue_valid;
  logic                    queue_ready;
  logic [FRAC_BITS-1:0]    hue;
  logic [FRAC_BITS-1:0]    saturation;
  logic [CHANNEL_BITS-1:0] brightness;

  // front: max/min, chroma, sector pick and numerator wrap
  rthc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .red       (s_tdata[CHANNEL_BITS-1:0]),
    .green     (s_tdata[2*CHANNEL_BITS-1:CHANNEL_BITS]),
    .blue      (s_tdata[3*CHANNEL_BITS-1:2*CHANNEL_BITS]),
    .out_valid (front_valid),
    .out_ready (front_ready),
    .out_item  (front_item)
  );

  // short queue so the front keeps taking pixels while the back is held
  rthc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_item   (front_item),
    .out_valid (queue_valid),
    .out_ready (queue_ready),
    .out_item  (queue_item)
  );

  // back: pipelined hue and saturation dividers, last stage is the output reg
  rthc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (queue_valid),
    .in_ready   (queue_ready),
    .in_item    (queue_item),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness)
  );

  assign m_tdata = M_DATA_W'({brightness, saturation, hue});

endmodule

>>> verif/rgb_to_hsv_converter_core_tb.sv
`timescale 1ns / 100ps

module rgb_to_hsv_converter_core_tb;
  import rthc_pkg::*;

  // cycles with no item moving on either side before the run is abandoned
  localparam int STALL_LIMIT = 4000;
  // pixels per random phase
  localparam int PHASE_PIXELS = 250;
  // settling time after the last result, well above the pipeline latency
  localparam int TAIL_CYCLES = 30;

  // one expected result, fields at the block's widths
  typedef struct packed {
    logic [FRAC_BITS-1:0]    hue;
    logic [FRAC_BITS-1:0]    saturation;
    logic [CHANNEL_BITS-1:0] brightness;
  } hsv_t;

  // Scoreboard: converts each accepted pixel into its expected HSV result
  // and checks results in arrival order against the oldest one waiting.
  class hsv_scoreboard;
    hsv_t expected_hsv[$];
    int   errors;
    int   pixels_in;
    int   results_out;

    function automatic hsv_t convert_pixel(logic [CHANNEL_BITS-1:0] r,
                                           logic [CHANNEL_BITS-1:0] g,
                                           logic [CHANNEL_BITS-1:0] b);
      hsv_t   res;
      longint rl;
      longint gl;
      longint bl;
      longint hi;
      longint lo;
      longint chroma;
      longint sector;
      longint diff;
      longint num;
      longint den;
      longint q;
      rl = longint'(r);
      gl = longint'(g);
      bl = longint'(b);
      hi = rl;
      lo = rl;
      if (gl > hi) hi = gl;
      if (bl > hi) hi = bl;
      if (gl < lo) lo = gl;
      if (bl < lo) lo = bl;
      chroma = hi - lo;
      res.brightness = hi[CHANNEL_BITS-1:0];
      // black pixel has no saturation; a pure colour gives exactly one
      // and clips to the largest Q0.16 code
      res.saturation = '0;
      if (hi != 0) begin
        q = (chroma << FRAC_BITS) / hi;
        if (q > 65535) q = 65535;
        res.saturation = q[FRAC_BITS-1:0];
      end
      // grey pixel has no hue; ties go to red first, then green
      res.hue = '0;
      if (chroma != 0) begin
        if (hi == rl) begin
          sector = 0;
          diff = gl - bl;
        end else if (hi == gl) begin
          sector = 2;
          diff = bl - rl;
        end else begin
          sector = 4;
          diff = rl - gl;
        end
        num = (sector * chroma + diff) << FRAC_BITS;
        den = 6 * chroma;
        // floor division; a negative hue wraps by one full turn
        if (num >= 0) q = num / den;
        else q = -((-num + den - 1) / den);
        res.hue = q[FRAC_BITS-1:0];
      end
      return res;
    endfunction

    function void note_pixel(logic [CHANNEL_BITS-1:0] r, logic [CHANNEL_BITS-1:0] g,
                             logic [CHANNEL_BITS-1:0] b);
      expected_hsv.push_back(convert_pixel(r, g, b));
      pixels_in++;
    endfunction

    function void check_result(logic [M_DATA_W-1:0] data);
      hsv_t got;
      hsv_t want;
      got.hue        = data[FRAC_BITS-1:0];
      got.saturation = data[2*FRAC_BITS-1:FRAC_BITS];
      got.brightness = data[2*FRAC_BITS+CHANNEL_BITS-1:2*FRAC_BITS];
      results_out++;
      if (expected_hsv.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: unexpected result h=%0d s=%0d v=%0d", got.hue,
                   got.saturation, got.brightness);
        return;
      end
      want = expected_hsv.pop_front();
      if (got.hue !== want.hue || got.saturation !== want.saturation ||
          got.brightness !== want.brightness) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: result %0d expected h=%0d s=%0d v=%0d, got h=%0d s=%0d v=%0d",
                   results_out, want.hue, want.saturation, want.brightness,
                   got.hue, got.saturation, got.brightness);
      end
    endfunction

    function void check_leftover();
      if (expected_hsv.size() != 0) begin
        errors++;
        $display("ERROR: %0d results never arrived", expected_hsv.size());
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;

  hsv_scoreboard sb;
  int            src_idle_pct = 0;
  int            snk_idle_pct = 0;
  int            quiet_cycles = 0;

  rgb_to_hsv_converter_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #10 clk = ~clk;

  // Result side: check every accepted item, then pick the next ready level.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
      m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  // Watchdog: abandon the run if nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("ERROR: no item moved for %0d cycles", STALL_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Offer one pixel after a random gap and hold it until accepted.
  // s_tvalid gets a single assignment per edge, so back-to-back items keep
  // it high without a glitch.
  task automatic send_pixel(input logic [CHANNEL_BITS-1:0] r,
                            input logic [CHANNEL_BITS-1:0] g,
                            input logic [CHANNEL_BITS-1:0] b);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {b, g, r};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_pixel(r, g, b);
  endtask

  // Stop offering and wait until every expected result is out.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_hsv.size() != 0) @(posedge clk);
  endtask

  // Random pixel, biased toward ties, greys, pure colours and extremes.
  task automatic random_pixel(output logic [CHANNEL_BITS-1:0] r,
                              output logic [CHANNEL_BITS-1:0] g,
                              output logic [CHANNEL_BITS-1:0] b);
    logic [CHANNEL_BITS-1:0] v;
    logic [CHANNEL_BITS-1:0] w;
    int                      kind;
    kind = $urandom_range(0, 9);
    r = CHANNEL_BITS'($urandom_range(0, 255));
    g = CHANNEL_BITS'($urandom_range(0, 255));
    b = CHANNEL_BITS'($urandom_range(0, 255));
    v = CHANNEL_BITS'($urandom_range(1, 255));
    w = CHANNEL_BITS'($urandom_range(0, 255) % v);
    case (kind)
      5: begin
        g = r;
        b = r;
      end
      6: begin
        // two channels share the maximum
        case ($urandom_range(0, 2))
          0: begin r = v; g = v; b = w; end
          1: begin r = w; g = v; b = v; end
          default: begin r = v; g = w; b = v; end
        endcase
      end
      7: begin
        case ($urandom_range(0, 2))
          0: r = '0;
          1: g = '0;
          default: b = '0;
        endcase
      end
      8: begin
        r = ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
        g = ($urandom_range(0, 1) != 0) ? 8'hfe : 8'h01;
        b = ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
        if ($urandom_range(0, 1) != 0) {r, g} = {g, r};
      end
      9: begin
        r = CHANNEL_BITS'($urandom_range(0, 3));
        g = CHANNEL_BITS'($urandom_range(0, 3));
        b = CHANNEL_BITS'($urandom_range(0, 3));
      end
      default: ;
    endcase
  endtask

  initial begin
    logic [CHANNEL_BITS-1:0] r;
    logic [CHANNEL_BITS-1:0] g;
    logic [CHANNEL_BITS-1:0] b;
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed pixels, sent back to back
    send_pixel(8'd0,   8'd0,   8'd0);    // black
    send_pixel(8'd255, 8'd255, 8'd255);  // white, grey
    send_pixel(8'd128, 8'd128, 8'd128);  // mid grey
    send_pixel(8'd255, 8'd0,   8'd0);    // pure red
    send_pixel(8'd0,   8'd255, 8'd0);    // pure green
    send_pixel(8'd0,   8'd0,   8'd255);  // pure blue
    send_pixel(8'd255, 8'd255, 8'd0);    // red/green tie
    send_pixel(8'd0,   8'd255, 8'd255);  // green/blue tie
    send_pixel(8'd255, 8'd0,   8'd255);  // red/blue tie, hue wraps
    send_pixel(8'd255, 8'd0,   8'd1);    // hue just below a full turn
    send_pixel(8'd200, 8'd10,  8'd100);  // red sector, negative
    send_pixel(8'd1,   8'd0,   8'd0);
    send_pixel(8'd1,   8'd1,   8'd0);
    send_pixel(8'd0,   8'd0,   8'd1);
    send_pixel(8'd255, 8'd254, 8'd253);  // low chroma, high value
    send_pixel(8'd10,  8'd20,  8'd30);
    send_pixel(8'd30,  8'd20,  8'd10);
    send_pixel(8'd20,  8'd30,  8'd10);
    send_pixel(8'haa,  8'h55,  8'haa);
    send_pixel(8'h55,  8'haa,  8'h55);
    drain_results();

    // random phases: receiver slow, then sender slow, then both flat out
    for (int phase = 0; phase < 3; phase++) begin
      src_idle_pct = (phase == 0) ? 35 : (phase == 1) ? 58 : 0;
      snk_idle_pct = (phase == 0) ? 58 : (phase == 1) ? 35 : 0;
      for (int n = 0; n < PHASE_PIXELS; n++) begin
        random_pixel(r, g, b);
        send_pixel(r, g, b);
      end
      drain_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    sb.check_leftover();
    $display("Converted %0d pixels (%0d results): corner colours, ties, greys,",
             sb.pixels_in, sb.results_out);
    $display("and random pixels under sender and receiver stalls; %0d errors", sb.errors);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
